@@ hdl/scfe_pkg.sv @@
// ----------------------------------------------------------------------------
// scfe_pkg
// Shared types and codes of the serial command frame exchange block.
// ----------------------------------------------------------------------------
package scfe_pkg;

	localparam logic [1:0] ACT_HOST     = 2'd0;
	localparam logic [1:0] ACT_LINE     = 2'd1;
	localparam logic [1:0] ACT_TICK     = 2'd2;
	localparam logic [1:0] ACT_RESERVED = 2'd3;

	localparam logic [1:0] KIND_TX     = 2'd0;
	localparam logic [1:0] KIND_REPLY  = 2'd1;
	localparam logic [1:0] KIND_STATUS = 2'd2;

	localparam logic [3:0] ST_OK           = 4'd0;
	localparam logic [3:0] ST_TOO_SHORT    = 4'd1;
	localparam logic [3:0] ST_ACK_TIMEOUT  = 4'd2;
	localparam logic [3:0] ST_NAK          = 4'd3;
	localparam logic [3:0] ST_BAD_ACK      = 4'd4;
	localparam logic [3:0] ST_HDR_TIMEOUT  = 4'd5;
	localparam logic [3:0] ST_BAD_HDR      = 4'd6;
	localparam logic [3:0] ST_BODY_TIMEOUT = 4'd7;
	localparam logic [3:0] ST_TOO_LONG     = 4'd8;

	localparam logic [7:0] FRAME_START = 8'hF2;
	localparam logic [7:0] FRAME_END   = 8'h03;
	localparam logic [7:0] BYTE_ACK    = 8'h06;
	localparam logic [7:0] BYTE_NAK    = 8'h15;

	localparam logic [0:0] REG_ADDR    = 1'd0;
	localparam logic [0:0] REG_TIMEOUT = 1'd1;

	typedef struct packed {
		logic [1:0] action;
		logic [7:0] data_byte;
		logic       last_payload;
	} in_item_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] out_byte;
		logic [3:0] status;
		logic       last;
	} out_item_t;

endpackage

@@ hdl/scfe_if.sv @@
// ----------------------------------------------------------------------------
// scfe_in_if / scfe_out_if
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
interface scfe_in_if;
	logic                 valid;
	logic                 ready;
	scfe_pkg::in_item_t   data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface scfe_out_if;
	logic                 valid;
	logic                 ready;
	scfe_pkg::out_item_t  data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

@@ hdl/scfe_front.sv @@
// ----------------------------------------------------------------------------
// scfe_front
// Accepts input items, drops those with no effect, queues the rest.
// ----------------------------------------------------------------------------
module scfe_front (
	input  logic               clk,
	input  logic               arst_n,
	scfe_in_if.sink            in_ch,
	output logic               q_valid,
	output scfe_pkg::in_item_t q_item,
	input  logic               q_ready
);

	logic               full_q;
	scfe_pkg::in_item_t item_q;
	logic               keep;

	assign keep = (in_ch.data.action == scfe_pkg::ACT_HOST) ||
		(in_ch.data.action == scfe_pkg::ACT_LINE) ||
		(in_ch.data.action == scfe_pkg::ACT_TICK);
	assign in_ch.ready = !full_q || q_ready;
	assign q_valid = full_q;
	assign q_item = item_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_q <= 1'b0;
		end else if (in_ch.ready) begin
			full_q <= in_ch.valid && keep;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.ready && in_ch.valid) begin
			item_q <= in_ch.data;
		end
	end

endmodule

@@ hdl/scfe_back.sv @@
// ----------------------------------------------------------------------------
// scfe_back
// Frame sequencer: stores the command, sends the frame, takes the reply.
// ----------------------------------------------------------------------------
module scfe_back #(
	parameter int COMMAND_DEPTH = 1024,
	parameter int REPLY_DEPTH   = 1024
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_valid,
	input  scfe_pkg::in_item_t q_item,
	output logic               q_ready,
	input  logic [7:0]         device_address,
	input  logic [31:0]        timeout_ticks,
	scfe_out_if.source         out_ch
);

	localparam int CAW = $clog2(COMMAND_DEPTH);
	localparam int RAW = $clog2(REPLY_DEPTH);
	localparam logic [16:0] CDEP = 17'(COMMAND_DEPTH);
	localparam logic [16:0] RDEP = 17'(REPLY_DEPTH);

	typedef enum logic [7:0] {
		PH_IDLE     = 8'b0000_0001,
		PH_SEND     = 8'b0000_0010,
		PH_WAIT_ACK = 8'b0000_0100,
		PH_WAIT_HDR = 8'b0000_1000,
		PH_WAIT_BDY = 8'b0001_0000,
		PH_SEND_ACK = 8'b0010_0000,
		PH_DELIVER  = 8'b0100_0000,
		PH_DONE     = 8'b1000_0000
	} phase_t;

	phase_t      phase_q;
	logic [16:0] count_q;
	logic [16:0] pos_q;
	logic [7:0]  chk_q;
	logic [15:0] rlen_q;
	logic [31:0] idle_q;
	logic [7:0]  cmem [COMMAND_DEPTH];
	logic [7:0]  rmem [REPLY_DEPTH];
	logic [7:0]  crd_q;
	logic [7:0]  rrd_q;

	logic        ovalid_q;
	scfe_pkg::out_item_t oitem_q;

	logic        take;
	logic        emit;
	logic [16:0] pos_n;
	logic [7:0]  fbyte;
	logic [31:0] idle_inc;
	logic [1:0]  act;
	logic [7:0]  dat;

	assign act = q_item.action;
	assign dat = q_item.data_byte;
	assign q_ready = !ovalid_q || out_ch.ready;
	assign take = q_valid && q_ready;
	assign out_ch.valid = ovalid_q;
	assign out_ch.data = oitem_q;
	assign idle_inc = idle_q + 32'd1;

	// Memory read data is prefetched one position ahead: each read is addressed
	// by pos_n, so the registered read data tracks pos_q (command reads skip the four header bytes).
	always_ff @(posedge clk) begin
		if (take && act == scfe_pkg::ACT_HOST && phase_q == PH_IDLE && count_q < CDEP) begin
			cmem[count_q[CAW-1:0]] <= dat;
		end
		crd_q <= cmem[pos_n[CAW-1:0] - CAW'(4)];
	end

	always_ff @(posedge clk) begin
		if (take && act == scfe_pkg::ACT_LINE && phase_q == PH_WAIT_BDY && pos_q < RDEP) begin
			rmem[pos_q[RAW-1:0]] <= dat;
		end
		rrd_q <= rmem[pos_n[RAW-1:0]];
	end

	always_comb begin
		if (pos_q == 17'd0)
			fbyte = scfe_pkg::FRAME_START;
		else if (pos_q == 17'd1)
			fbyte = device_address;
		else if (pos_q == 17'd2)
			fbyte = count_q[15:8];
		else if (pos_q == 17'd3)
			fbyte = count_q[7:0];
		else if (pos_q < count_q + 17'd4)
			fbyte = crd_q;
		else if (pos_q == count_q + 17'd4)
			fbyte = scfe_pkg::FRAME_END;
		else
			fbyte = chk_q;
	end

	// Next position and whether this beat produces a result.
	always_comb begin
		pos_n = pos_q;
		emit = 1'b0;
		if (take) begin
			case (phase_q)
				PH_IDLE: if (act == scfe_pkg::ACT_HOST) begin
					emit = q_item.last_payload && count_q == 17'd0;
				end
				PH_SEND: if (act == scfe_pkg::ACT_TICK) begin
					emit = 1'b1;
					pos_n = (pos_q + 17'd1 >= count_q + 17'd6) ? 17'd0 : pos_q + 17'd1;
				end
				PH_WAIT_ACK, PH_WAIT_HDR, PH_WAIT_BDY: begin
					if (act == scfe_pkg::ACT_TICK) begin
						if (idle_inc >= timeout_ticks) begin
							emit = 1'b1;
							pos_n = 17'd0;
						end
					end else if (act == scfe_pkg::ACT_LINE) begin
						if (phase_q == PH_WAIT_ACK) begin
							pos_n = 17'd0;
							emit = (dat != scfe_pkg::BYTE_ACK);
						end else if (phase_q == PH_WAIT_HDR) begin
							if (pos_q == 17'd0 && dat != scfe_pkg::FRAME_START) begin
								emit = 1'b1;
								pos_n = 17'd0;
							end else if (pos_q == 17'd3) begin
								pos_n = 17'd0;
								emit = ({1'b0, rlen_q[15:8], dat} + 17'd2 > RDEP);
							end else begin
								pos_n = pos_q + 17'd1;
							end
						end else begin
							pos_n = (pos_q + 17'd1 >= {1'b0, rlen_q} + 17'd2) ? 17'd0 :
								pos_q + 17'd1;
						end
					end
				end
				PH_SEND_ACK: if (act == scfe_pkg::ACT_TICK) begin
					emit = 1'b1;
					pos_n = 17'd0;
				end
				PH_DELIVER: if (act == scfe_pkg::ACT_TICK) begin
					emit = 1'b1;
					pos_n = pos_q + 17'd1;
				end
				PH_DONE: if (act == scfe_pkg::ACT_TICK) begin
					emit = 1'b1;
					pos_n = 17'd0;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			count_q  <= '0;
			pos_q    <= '0;
			chk_q    <= '0;
			rlen_q   <= '0;
			idle_q   <= '0;
			ovalid_q <= 1'b0;
			oitem_q  <= '0;
		end else begin
			if (emit) ovalid_q <= 1'b1;
			else if (out_ch.ready) ovalid_q <= 1'b0;
			pos_q <= pos_n;
			if (take) begin
				case (phase_q)
					PH_IDLE: if (act == scfe_pkg::ACT_HOST) begin
						if (q_item.last_payload && count_q == 17'd0) begin
							oitem_q <= '{scfe_pkg::KIND_STATUS, 8'd0,
								scfe_pkg::ST_TOO_SHORT, 1'b0};
						end else begin
							if (count_q < CDEP) count_q <= count_q + 17'd1;
							if (q_item.last_payload) begin
								phase_q <= PH_SEND;
								chk_q <= '0;
							end
						end
					end
					PH_SEND: if (act == scfe_pkg::ACT_TICK) begin
						chk_q <= chk_q ^ fbyte;
						oitem_q <= '{scfe_pkg::KIND_TX, fbyte, scfe_pkg::ST_OK, 1'b0};
						if (pos_q + 17'd1 >= count_q + 17'd6) begin
							phase_q <= PH_WAIT_ACK;
							idle_q <= '0;
						end
					end
					PH_WAIT_ACK, PH_WAIT_HDR, PH_WAIT_BDY: begin
						if (act == scfe_pkg::ACT_TICK) begin
							if (idle_inc >= timeout_ticks) begin
								phase_q <= PH_IDLE;
								count_q <= '0;
								chk_q <= '0;
								idle_q <= '0;
								oitem_q <= '{scfe_pkg::KIND_STATUS, 8'd0,
									(phase_q == PH_WAIT_ACK) ? scfe_pkg::ST_ACK_TIMEOUT :
									(phase_q == PH_WAIT_HDR) ? scfe_pkg::ST_HDR_TIMEOUT :
									scfe_pkg::ST_BODY_TIMEOUT, 1'b0};
							end else begin
								idle_q <= idle_inc;
							end
						end else if (act == scfe_pkg::ACT_LINE) begin
							idle_q <= '0;
							if (phase_q == PH_WAIT_ACK) begin
								if (dat == scfe_pkg::BYTE_ACK) begin
									phase_q <= PH_WAIT_HDR;
								end else begin
									phase_q <= PH_IDLE;
									count_q <= '0;
									chk_q <= '0;
									oitem_q <= '{scfe_pkg::KIND_STATUS, 8'd0,
										(dat == scfe_pkg::BYTE_NAK) ? scfe_pkg::ST_NAK :
										scfe_pkg::ST_BAD_ACK, 1'b0};
								end
							end else if (phase_q == PH_WAIT_HDR) begin
								if (pos_q == 17'd2) rlen_q <= {dat, 8'd0};
								if (pos_q == 17'd0 && dat != scfe_pkg::FRAME_START) begin
									phase_q <= PH_IDLE;
									count_q <= '0;
									chk_q <= '0;
									oitem_q <= '{scfe_pkg::KIND_STATUS, 8'd0,
										scfe_pkg::ST_BAD_HDR, 1'b0};
								end else if (pos_q == 17'd3) begin
									rlen_q <= {rlen_q[15:8], dat};
									if ({1'b0, rlen_q[15:8], dat} + 17'd2 > RDEP) begin
										phase_q <= PH_IDLE;
										count_q <= '0;
										chk_q <= '0;
										oitem_q <= '{scfe_pkg::KIND_STATUS, 8'd0,
											scfe_pkg::ST_TOO_LONG, 1'b0};
									end else begin
										phase_q <= PH_WAIT_BDY;
									end
								end
							end else begin
								if (pos_q + 17'd1 >= {1'b0, rlen_q} + 17'd2)
									phase_q <= PH_SEND_ACK;
							end
						end
					end
					PH_SEND_ACK: if (act == scfe_pkg::ACT_TICK) begin
						phase_q <= (rlen_q > 16'd2) ? PH_DELIVER : PH_DONE;
						oitem_q <= '{scfe_pkg::KIND_TX, scfe_pkg::BYTE_ACK,
							scfe_pkg::ST_OK, 1'b0};
					end
					PH_DELIVER: if (act == scfe_pkg::ACT_TICK) begin
						oitem_q <= '{scfe_pkg::KIND_REPLY,
							(pos_q < RDEP) ? rrd_q : 8'd0, scfe_pkg::ST_OK,
							(pos_q + 17'd1 >= {1'b0, rlen_q})};
						if (pos_q + 17'd1 >= {1'b0, rlen_q}) phase_q <= PH_DONE;
					end
					PH_DONE: if (act == scfe_pkg::ACT_TICK) begin
						phase_q <= PH_IDLE;
						count_q <= '0;
						chk_q <= '0;
						idle_q <= '0;
						oitem_q <= '{scfe_pkg::KIND_STATUS, 8'd0, scfe_pkg::ST_OK, 1'b0};
					end
					default: ;
				endcase
			end
		end
	end

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		ovalid_q && !out_ch.ready |=> ovalid_q && $stable(oitem_q))
		else $error("result dropped under stall");
	a_idle_count: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_IDLE |-> count_q <= CDEP)
		else $error("command count overflow");
	a_phase_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(phase_q))
		else $error("phase not one-hot");
	a_no_take_full: assert property (@(posedge clk) disable iff (!arst_n)
		ovalid_q && !out_ch.ready |-> !q_ready)
		else $error("accepted while result stalled");

endmodule

@@ hdl/serial_command_frame_exchange_core.sv @@
// ----------------------------------------------------------------------------
// serial_command_frame_exchange_core
// Host-side framed command exchange with XOR check and ACK/NAK handshake.
// ----------------------------------------------------------------------------
// Usage: in_ch carries host command bytes, received line bytes and ticks;
// out_ch returns bytes to transmit, reply payload bytes and a final status.
// cfg_we/cfg_index/cfg_data write device_address (0) and timeout_ticks (1);
// the user writes them only while the block is idle; the block does not enforce it.
// One item is accepted every cycle when out_ch is not stalled. An item's
// result, if any, reaches out_ch through the front queue stage, which loads
// at the accepting edge, and then the sequencer's output register, which
// makes it valid on out_ch.
// Command and reply bytes sit in two memories, each one write and one
// registered read port; reads are prefetched one position ahead.
// Reset empties both stages and returns the sequencer to idle with an empty
// command store; no clearing pass is needed.
// A stalled out_ch holds its beat; the front stage then fills and in_ch
// ready drops until the result is taken.
// ----------------------------------------------------------------------------
module serial_command_frame_exchange_core #(
	parameter int COMMAND_DEPTH = 1024,
	parameter int REPLY_DEPTH   = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	scfe_in_if.sink     in_ch,
	scfe_out_if.source  out_ch,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [31:0] cfg_data
);

	logic [7:0]  addr_q;
	logic [31:0] tmo_q;
	logic               q_valid;
	logic               q_ready;
	scfe_pkg::in_item_t q_item;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q <= 8'd0;
			tmo_q  <= 32'd5000;
		end else if (cfg_we) begin
			case (cfg_index)
				scfe_pkg::REG_ADDR:    addr_q <= cfg_data[7:0];
				scfe_pkg::REG_TIMEOUT: tmo_q <= cfg_data;
				default: ;
			endcase
		end
	end

	scfe_front u_front (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch),
		.q_valid(q_valid), .q_item(q_item), .q_ready(q_ready)
	);

	scfe_back #(.COMMAND_DEPTH(COMMAND_DEPTH), .REPLY_DEPTH(REPLY_DEPTH)) u_back (
		.clk(clk), .arst_n(arst_n), .q_valid(q_valid), .q_item(q_item),
		.q_ready(q_ready), .device_address(addr_q), .timeout_ticks(tmo_q),
		.out_ch(out_ch)
	);

endmodule
